FILE: rtl/ckb_pkg.sv
`default_nettype none

package ckb_pkg;

   localparam int CHANNEL_BITS_DEFAULT = 8;
   localparam int KEY_GREEN_RESET      = 255;
   localparam int CSR_INDEX_BITS       = 3;
   localparam int NUM_CHANNELS         = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_KEY_RED      = 3'd0,
      REG_KEY_GREEN    = 3'd1,
      REG_KEY_BLUE     = 3'd2,
      REG_INNER_RADIUS = 3'd3,
      REG_OUTER_RADIUS = 3'd4
   } csr_reg_type;

endpackage

`default_nettype wire

FILE: rtl/chroma_key_blend_unit.sv
`default_nettype none

// chroma key compositing, one foreground/background pixel pair per beat
//
// req channel: req_tdata carries the pixel pair, req_tready/req_tvalid hand it over.
// rsp channel: rsp_tdata carries the composited pixel.
// csr channel: register index and data, always ready. Writes are meant for idle
// periods; a write to an index past the outer radius is dropped.
//
// the squared rgb distance to the key colour is checked against the squared
// radii: below inner gives background, above outer gives foreground, otherwise
// the floor average of both pixels.
//
// four register stages (abs diff, square, sum, compare/select); throughput is
// one beat per cycle while rsp_tready is high, set by the fully pipelined
// multipliers and adders.
// a stalled rsp_tready holds the output and backs up stage by stage; a stage
// with a bubble keeps taking beats, so nothing is lost or repeated.
// reset empties the pipeline and loads the key green, radii 0 defaults.
module chroma_key_blend_unit #(
   parameter int CHANNEL_BITS = ckb_pkg::CHANNEL_BITS_DEFAULT
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   // fg_red, fg_green, fg_blue, bg_red, bg_green, bg_blue
   input  wire logic [((6*CHANNEL_BITS+7)/8)*8-1:0]        req_tdata,
   input  wire logic                                       req_tvalid,
   output logic                                            req_tready,
   // out_red, out_green, out_blue
   output logic [((3*CHANNEL_BITS+7)/8)*8-1:0]             rsp_tdata,
   output logic                                            rsp_tvalid,
   input  wire logic                                       rsp_tready,
   input  wire logic                                       csr_valid,
   output logic                                            csr_ready,
   input  wire logic [ckb_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  wire logic [CHANNEL_BITS:0]                      csr_data
);
   import ckb_pkg::*;

   localparam int CB        = CHANNEL_BITS;
   localparam int RB        = CHANNEL_BITS + 1;
   localparam int SQ_BITS   = 2 * CHANNEL_BITS;
   localparam int DIST_BITS = 2 * RB;
   localparam int RSP_BITS  = ((3*CHANNEL_BITS+7)/8)*8;
   localparam logic [CHANNEL_BITS-1:0] KEY_GREEN_INIT = CHANNEL_BITS'(KEY_GREEN_RESET);

   // configuration
   logic [CB-1:0] key_ff [NUM_CHANNELS];
   logic [RB-1:0] inner_radius_ff, outer_radius_ff;
   logic [DIST_BITS-1:0] inner_sq_ff, outer_sq_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0]       <= '0;
         key_ff[1]       <= KEY_GREEN_INIT;
         key_ff[2]       <= '0;
         inner_radius_ff <= '0;
         outer_radius_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            REG_KEY_RED:      key_ff[0] <= csr_data[CB-1:0];
            REG_KEY_GREEN:    key_ff[1] <= csr_data[CB-1:0];
            REG_KEY_BLUE:     key_ff[2] <= csr_data[CB-1:0];
            REG_INNER_RADIUS: inner_radius_ff <= csr_data;
            REG_OUTER_RADIUS: outer_radius_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // user must change radii only when idle (unenforced) so squares settle in time
   always_ff @(posedge clock) begin
      inner_sq_ff <= DIST_BITS'(inner_radius_ff) * DIST_BITS'(inner_radius_ff);
      outer_sq_ff <= DIST_BITS'(outer_radius_ff) * DIST_BITS'(outer_radius_ff);
   end

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;

   assign adv4       = !v4_ff || rsp_tready;
   assign adv3       = !v3_ff || adv4;
   assign adv2       = !v2_ff || adv3;
   assign adv1       = !v1_ff || adv2;
   assign req_tready = adv1;
   assign rsp_tvalid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_tvalid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   // stage 1: absolute differences
   logic [NUM_CHANNELS-1:0][CB-1:0] fg1_in, bg1_in, ad1_in;
   logic [NUM_CHANNELS-1:0][CB-1:0] fg1_ff, bg1_ff, ad1_ff;

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         fg1_in[c] = req_tdata[c*CB +: CB];
         bg1_in[c] = req_tdata[(NUM_CHANNELS+c)*CB +: CB];
         ad1_in[c] = (fg1_in[c] >= key_ff[c]) ? fg1_in[c] - key_ff[c]
                                               : key_ff[c] - fg1_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         fg1_ff <= fg1_in;
         bg1_ff <= bg1_in;
         ad1_ff <= ad1_in;
      end
   end

   // stage 2: squares
   logic [NUM_CHANNELS-1:0][SQ_BITS-1:0] sq2_in, sq2_ff;
   logic [NUM_CHANNELS-1:0][CB-1:0]      fg2_ff, bg2_ff;

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         sq2_in[c] = SQ_BITS'(ad1_ff[c]) * SQ_BITS'(ad1_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         sq2_ff <= sq2_in;
         fg2_ff <= fg1_ff;
         bg2_ff <= bg1_ff;
      end
   end

   // stage 3: distance sum
   logic [DIST_BITS-1:0]            dist3_in, dist3_ff;
   logic [NUM_CHANNELS-1:0][CB-1:0] fg3_ff, bg3_ff;

   assign dist3_in = DIST_BITS'(sq2_ff[0]) + DIST_BITS'(sq2_ff[1]) + DIST_BITS'(sq2_ff[2]);

   always_ff @(posedge clock) begin
      if (adv3) begin
         dist3_ff <= dist3_in;
         fg3_ff   <= fg2_ff;
         bg3_ff   <= bg2_ff;
      end
   end

   // stage 4: compare and select, inner test wins
   logic [NUM_CHANNELS-1:0][CB-1:0] pix4_in, pix4_ff;
   logic [CB:0]                     blend_sum;

   always_comb begin
      blend_sum = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         blend_sum = RB'(fg3_ff[c]) + RB'(bg3_ff[c]);
         if (dist3_ff < inner_sq_ff) begin
            pix4_in[c] = bg3_ff[c];
         end else if (dist3_ff > outer_sq_ff) begin
            pix4_in[c] = fg3_ff[c];
         end else begin
            pix4_in[c] = blend_sum[CB:1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv4) pix4_ff <= pix4_in;
   end

   assign rsp_tdata = RSP_BITS'(pix4_ff);

endmodule

`default_nettype wire

FILE: rtl/ckb_checker.sv
`default_nettype none

module ckb_checker #(
   parameter int CHANNEL_BITS = ckb_pkg::CHANNEL_BITS_DEFAULT
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic [((6*CHANNEL_BITS+7)/8)*8-1:0] req_tdata,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic [((3*CHANNEL_BITS+7)/8)*8-1:0] rsp_tdata,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic                                csr_valid,
   input wire logic                                csr_ready,
   input wire logic [ckb_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input wire logic [CHANNEL_BITS:0]               csr_data
);
   import ckb_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_tdata, req_tvalid, csr_valid, csr_index, csr_data};

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   // an empty output stage means every stage can move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty output");

   // output ready propagates to the input side
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output is taken");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr channel not ready");

endmodule

bind chroma_key_blend_unit ckb_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_ckb_checker (.*);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ckb_pkg::*;

   localparam int CB          = CHANNEL_BITS_DEFAULT;
   localparam int RADIUS_BITS = CB + 1;
   localparam int DIST_BITS   = 2 * RADIUS_BITS + 2;
   localparam int NUM_DIRECTED    = 20;
   localparam int NUM_PHASES      = 9;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int INDEX_TOP       = 2 ** CSR_INDEX_BITS - 1;

   // packed so that red sits in the low byte, as on the bus
   typedef struct packed {
      logic [CB-1:0] blue;
      logic [CB-1:0] green;
      logic [CB-1:0] red;
   } rgb_type;

   typedef struct packed {
      rgb_type                key;
      logic [RADIUS_BITS-1:0] inner;
      logic [RADIUS_BITS-1:0] outer;
   } key_setting_type;

   typedef struct packed {
      key_setting_type setting;
      rgb_type         fg;
      rgb_type         bg;
      logic            typed;
      rgb_type         expected;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [((6*CB+7)/8)*8-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [((3*CB+7)/8)*8-1:0] rsp_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [RADIUS_BITS-1:0] csr_data = '0;

   key_setting_type active_setting;
   rgb_type         expected_pixels [$];
   bit              pacing = 1'b1;
   int              errors = 0;
   int              pairs_sent = 0;
   int              pixels_checked = 0;
   int              settings_applied = 0;

   chroma_key_blend_unit #(.CHANNEL_BITS(CB)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic rgb_type rgb(input int r, input int g, input int b);
      rgb_type p;
      p.red   = r[CB-1:0];
      p.green = g[CB-1:0];
      p.blue  = b[CB-1:0];
      return p;
   endfunction

   function automatic logic [DIST_BITS-1:0] channel_sq_dist(input logic [CB-1:0] a,
                                                           input logic [CB-1:0] b);
      logic [CB-1:0] diff;
      diff = (a >= b) ? a - b : b - a;
      return DIST_BITS'(diff) * DIST_BITS'(diff);
   endfunction

   function automatic rgb_type composite_pixel(input rgb_type fg, input rgb_type bg);
      logic [DIST_BITS-1:0] distance, inner_sq, outer_sq;
      rgb_type blend;
      distance = channel_sq_dist(fg.red, active_setting.key.red)
               + channel_sq_dist(fg.green, active_setting.key.green)
               + channel_sq_dist(fg.blue, active_setting.key.blue);
      inner_sq = DIST_BITS'(active_setting.inner) * DIST_BITS'(active_setting.inner);
      outer_sq = DIST_BITS'(active_setting.outer) * DIST_BITS'(active_setting.outer);
      blend.red   = CB'(({1'b0, fg.red} + bg.red) >> 1);
      blend.green = CB'(({1'b0, fg.green} + bg.green) >> 1);
      blend.blue  = CB'(({1'b0, fg.blue} + bg.blue) >> 1);
      if (distance < inner_sq) return bg;
      if (distance > outer_sq) return fg;
      return blend;
   endfunction

   function automatic rgb_type random_pixel();
      return rgb($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
   endfunction

   function automatic int jitter(input int center, input int spread);
      int v;
      v = center + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v;
   endfunction

   // foreground pixels around the key colour so all three regions get hit
   function automatic rgb_type pixel_near_key();
      int spread;
      spread = (active_setting.outer > active_setting.inner) ? active_setting.outer
                                                             : active_setting.inner;
      spread = spread * 3 / 4 + 3;
      if (spread > 255) spread = 255;
      return rgb(jitter(active_setting.key.red, spread),
                 jitter(active_setting.key.green, spread),
                 jitter(active_setting.key.blue, spread));
   endfunction

   function automatic key_setting_type random_setting();
      key_setting_type s;
      s.key = random_pixel();
      case ($urandom_range(0, 5))
         0: begin
            s.inner = $urandom_range(0, 1) ? '1 : '0;
            s.outer = $urandom_range(0, 1) ? '1 : '0;
         end
         1: begin
            // inner past outer, the inner test wins
            s.outer = RADIUS_BITS'($urandom_range(0, 60));
            s.inner = RADIUS_BITS'(s.outer + $urandom_range(1, 60));
         end
         default: begin
            s.inner = RADIUS_BITS'($urandom_range(0, 80));
            s.outer = RADIUS_BITS'(s.inner + $urandom_range(0, 80));
         end
      endcase
      return s;
   endfunction

   // stall bursts on the result side
   initial begin
      forever begin
         @(posedge clock);
         if (pacing && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic report_channel(input string name, input logic [CB-1:0] want,
                                 input logic [CB-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rgb_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            report_channel("out_red", want.red, got.red);
            report_channel("out_green", want.green, got.green);
            report_channel("out_blue", want.blue, got.blue);
            pixels_checked++;
         end
      end
   end

   task automatic wait_drain();
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [RADIUS_BITS-1:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         REG_KEY_RED:      active_setting.key.red   = value[CB-1:0];
         REG_KEY_GREEN:    active_setting.key.green = value[CB-1:0];
         REG_KEY_BLUE:     active_setting.key.blue  = value[CB-1:0];
         REG_INNER_RADIUS: active_setting.inner     = value;
         REG_OUTER_RADIUS: active_setting.outer     = value;
         default: ;
      endcase
   endtask

   task automatic retune(input key_setting_type target);
      req_tvalid <= 1'b0;
      wait_drain();
      // key writes carry a random stray top bit that must be masked
      write_register(REG_KEY_RED, {1'($urandom_range(0, 1)), target.key.red});
      write_register(REG_KEY_GREEN, {1'($urandom_range(0, 1)), target.key.green});
      write_register(REG_KEY_BLUE, {1'($urandom_range(0, 1)), target.key.blue});
      write_register(REG_INNER_RADIUS, target.inner);
      write_register(REG_OUTER_RADIUS, target.outer);
      write_register(CSR_INDEX_BITS'($urandom_range(REG_OUTER_RADIUS + 1, INDEX_TOP)),
                     RADIUS_BITS'($urandom));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   task automatic send_pixel_pair(input rgb_type fg, input rgb_type bg, input logic typed,
                                  input rgb_type typed_out);
      if (pacing && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tdata  <= {bg, fg};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_pixels.push_back(typed ? typed_out : composite_pixel(fg, bg));
      pairs_sent++;
   endtask

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      // reset values: only an exact key match blends
      '{'{rgb(0, KEY_GREEN_RESET, 0), 9'd0, 9'd0}, rgb(0, 255, 0), rgb(255, 255, 255),
        1'b1, rgb(127, 255, 127)},
      '{'{rgb(0, KEY_GREEN_RESET, 0), 9'd0, 9'd0}, rgb(255, 0, 255), rgb(0, 0, 0),
        1'b1, rgb(255, 0, 255)},
      '{'{rgb(0, KEY_GREEN_RESET, 0), 9'd0, 9'd0}, rgb(0, 0, 0), rgb(255, 255, 255),
        1'b1, rgb(0, 0, 0)},
      // distances below, on and above each bound; those sitting on a bound blend
      '{'{rgb(100, 100, 100), 9'd3, 9'd5}, rgb(100, 100, 100), rgb(10, 20, 30),
        1'b1, rgb(10, 20, 30)},
      '{'{rgb(100, 100, 100), 9'd3, 9'd5}, rgb(101, 102, 100), rgb(10, 20, 30),
        1'b1, rgb(10, 20, 30)},
      '{'{rgb(100, 100, 100), 9'd3, 9'd5}, rgb(103, 100, 100), rgb(11, 20, 31),
        1'b1, rgb(57, 60, 65)},
      '{'{rgb(100, 100, 100), 9'd3, 9'd5}, rgb(102, 102, 102), rgb(1, 2, 3),
        1'b0, rgb(0, 0, 0)},
      '{'{rgb(100, 100, 100), 9'd3, 9'd5}, rgb(105, 100, 100), rgb(0, 0, 0),
        1'b1, rgb(52, 50, 50)},
      '{'{rgb(100, 100, 100), 9'd3, 9'd5}, rgb(104, 103, 100), rgb(200, 201, 202),
        1'b0, rgb(0, 0, 0)},
      '{'{rgb(100, 100, 100), 9'd3, 9'd5}, rgb(106, 100, 100), rgb(0, 0, 0),
        1'b1, rgb(106, 100, 100)},
      // inner radius larger than outer
      '{'{rgb(100, 100, 100), 9'd5, 9'd3}, rgb(104, 100, 100), rgb(7, 8, 9),
        1'b1, rgb(7, 8, 9)},
      '{'{rgb(100, 100, 100), 9'd5, 9'd3}, rgb(105, 100, 100), rgb(7, 8, 9),
        1'b1, rgb(105, 100, 100)},
      '{'{rgb(100, 100, 100), 9'd5, 9'd3}, rgb(103, 100, 100), rgb(7, 8, 9),
        1'b1, rgb(7, 8, 9)},
      // widest radii cover every possible distance; the last rows use radii 256 and 255
      '{'{rgb(255, 255, 255), 9'd511, 9'd511}, rgb(0, 0, 0), rgb(1, 2, 3),
        1'b1, rgb(1, 2, 3)},
      '{'{rgb(255, 255, 255), 9'd511, 9'd511}, rgb(255, 255, 255), rgb(4, 5, 6),
        1'b1, rgb(4, 5, 6)},
      '{'{rgb(0, 0, 0), 9'd0, 9'd511}, rgb(255, 255, 255), rgb(255, 255, 255),
        1'b1, rgb(255, 255, 255)},
      '{'{rgb(0, 0, 0), 9'd0, 9'd511}, rgb(255, 255, 255), rgb(0, 0, 0),
        1'b1, rgb(127, 127, 127)},
      '{'{rgb(0, 0, 0), 9'd0, 9'd511}, rgb(0, 0, 0), rgb(255, 255, 255),
        1'b1, rgb(127, 127, 127)},
      '{'{rgb(90, 165, 60), 9'd256, 9'd255}, rgb(165, 90, 195), rgb(60, 195, 90),
        1'b0, rgb(0, 0, 0)},
      '{'{rgb(90, 165, 60), 9'd256, 9'd255}, rgb(90, 165, 60), rgb(255, 0, 255),
        1'b0, rgb(0, 0, 0)}
   };

   initial begin
      int phase, n;
      rgb_type fg;
      active_setting = '{rgb(0, KEY_GREEN_RESET, 0), '0, '0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].setting != active_setting) retune(directed_rows[i].setting);
         send_pixel_pair(directed_rows[i].fg, directed_rows[i].bg, directed_rows[i].typed,
                         directed_rows[i].expected);
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         // the closing phase runs with no idling on either side
         pacing = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
         retune(random_setting());
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            fg = ($urandom_range(0, 3) == 0) ? random_pixel() : pixel_near_key();
            send_pixel_pair(fg, random_pixel(), 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      wait_drain();
      repeat (12) @(posedge clock);
      errors += expected_pixels.size();

      $display("sent %0d pixel pairs under %0d key settings, checked %0d composited pixels",
               pairs_sent, settings_applied, pixels_checked);
      $display("mismatches or stray beats: %0d", errors);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
